// File: hw/rtl/stld_pkg.sv
// Shared types and constants of the sync/type/length deframer.
// Depends on nothing; every other file of the block imports it.
package stld_pkg;

  localparam logic [7:0] SYNC_FIRST = 8'h55;
  localparam logic [7:0] SYNC_SECOND = 8'hAA;
  localparam logic [15:0] MAX_LEN_RESET = 16'd532;

  typedef enum logic [1:0] {
    EV_BYTE  = 2'd0,
    EV_EMPTY = 2'd1,
    EV_DROP  = 2'd2
  } event_kind_e;

  typedef struct packed {
    event_kind_e kind;
    logic [7:0]  frame_type;
    logic [15:0] frame_length;
    logic [15:0] byte_position;
    logic [7:0]  payload_byte;
    logic        last;
  } result_t;

endpackage

// File: hw/rtl/sync_type_length_deframer_unit.sv
// Byte-serial deframer for sync/type/length frames.
// Input beats carry one received byte each; the parser hunts for the sync pair
// 0x55 then 0xAA, reads a type byte and a little-endian 16-bit length, and then
// tags each payload byte with type, length, position and a last flag.
// Oversized frames give one drop beat and empty frames give one empty beat;
// sync, type and length bytes give no output beat.
// One input beat is accepted per cycle while in_stall_o is low; each result is
// registered in the output register, or in the skid register during a stall.
// A skid register lets one more input beat in while the output is stalled;
// in_stall_o rises only once that skid register holds a result.
// The maximum payload length is written over the APB port at address 0 and
// resets to 532. Reset returns the parser to the sync hunt and empties both
// output registers. Depends on stld_pkg, stld_cfg_regs, stld_parser and
// stld_out_buf.
module sync_type_length_deframer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  event_kind_o,
  output logic [7:0]  frame_type_o,
  output logic [15:0] frame_length_o,
  output logic [15:0] byte_position_o,
  output logic [7:0]  payload_byte_o,
  output logic        last_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import stld_pkg::*;

  logic [15:0] max_len;
  logic        accept;
  logic        res_valid;
  result_t     res;
  result_t     out_data;
  logic        buf_full;

  stld_cfg_regs u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .max_len_o (max_len)
  );

  assign in_stall_o = buf_full;
  assign accept = in_valid_i && !buf_full;

  stld_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .rx_byte_i   (rx_byte_i),
    .max_len_i   (max_len),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  stld_out_buf u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept && res_valid),
    .push_data_i (res),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data)
  );

  assign event_kind_o = out_data.kind;
  assign frame_type_o = out_data.frame_type;
  assign frame_length_o = out_data.frame_length;
  assign byte_position_o = out_data.byte_position;
  assign payload_byte_o = out_data.payload_byte;
  assign last_o = out_data.last;

endmodule

// File: hw/rtl/stld_cfg_regs.sv
// APB-style configuration register holding the maximum payload length.
// Depends on stld_pkg for the reset value.
module stld_cfg_regs (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [15:0] max_len_o
);
  import stld_pkg::*;

  logic [15:0] max_len_q;
  logic [15:0] max_len_d;
  logic        sel_max_len;

  assign sel_max_len = (paddr[2] == 1'b0);
  assign pready = 1'b1;

  always_comb begin
    max_len_d = max_len_q;
    if (psel && penable && pwrite && sel_max_len) begin
      max_len_d = pwdata[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MAX_LEN_RESET;
    end else begin
      max_len_q <= max_len_d;
    end
  end

  assign prdata = sel_max_len ? {16'd0, max_len_q} : 32'd0;
  assign max_len_o = max_len_q;

endmodule

// File: hw/rtl/stld_parser.sv
// Frame parser: sync hunt, type and length capture, payload byte tagging.
// Depends on stld_pkg for the sync constants and the result type.
module stld_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        rx_byte_i,
  input  logic [15:0]       max_len_i,
  output logic              res_valid_o,
  output stld_pkg::result_t res_o
);
  import stld_pkg::*;

  typedef enum logic [2:0] {
    PH_HUNT   = 3'd0,
    PH_SYNC2  = 3'd1,
    PH_TYPE   = 3'd2,
    PH_LEN_LO = 3'd3,
    PH_LEN_HI = 3'd4,
    PH_BODY   = 3'd5
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [7:0]  type_q, type_d;
  logic [15:0] len_q, len_d;
  logic [15:0] count_q, count_d;
  logic [15:0] len_full;
  logic [15:0] count_inc;

  assign len_full = {rx_byte_i, len_q[7:0]};
  assign count_inc = count_q + 16'd1;

  always_comb begin
    phase_d = phase_q;
    type_d = type_q;
    len_d = len_q;
    count_d = count_q;
    res_valid_o = 1'b0;
    res_o.kind = EV_BYTE;
    res_o.frame_type = type_q;
    res_o.frame_length = len_q;
    res_o.byte_position = 16'd0;
    res_o.payload_byte = 8'd0;
    res_o.last = 1'b1;
    case (phase_q)
      PH_SYNC2: begin
        if (rx_byte_i == SYNC_SECOND) begin
          phase_d = PH_TYPE;
          count_d = 16'd0;
          len_d = 16'd0;
        end else if (rx_byte_i != SYNC_FIRST) begin
          phase_d = PH_HUNT;
        end
      end
      PH_TYPE: begin
        type_d = rx_byte_i;
        phase_d = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        len_d = {8'd0, rx_byte_i};
        phase_d = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        len_d = len_full;
        res_o.frame_length = len_full;
        if (len_full > max_len_i) begin
          phase_d = PH_HUNT;
          res_valid_o = 1'b1;
          res_o.kind = EV_DROP;
        end else if (len_full == 16'd0) begin
          phase_d = PH_HUNT;
          res_valid_o = 1'b1;
          res_o.kind = EV_EMPTY;
        end else begin
          phase_d = PH_BODY;
        end
      end
      PH_BODY: begin
        count_d = count_inc;
        res_valid_o = 1'b1;
        res_o.kind = EV_BYTE;
        res_o.byte_position = count_q;
        res_o.payload_byte = rx_byte_i;
        res_o.last = (count_inc == len_q);
        if (count_inc == len_q) begin
          phase_d = PH_HUNT;
        end
      end
      default: begin
        phase_d = (rx_byte_i == SYNC_FIRST) ? PH_SYNC2 : PH_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      type_q <= 8'd0;
      len_q <= 16'd0;
      count_q <= 16'd0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      type_q <= type_d;
      len_q <= len_d;
      count_q <= count_d;
    end
  end

endmodule

// File: hw/rtl/stld_out_buf.sv
// Result register with a skid stage between the parser and the output channel.
// Depends on stld_pkg for the result type.
module stld_out_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  stld_pkg::result_t push_data_i,
  output logic              full_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output stld_pkg::result_t out_data_o
);
  import stld_pkg::*;

  logic    out_valid_q, out_valid_d;
  logic    skid_valid_q, skid_valid_d;
  result_t out_q, out_d;
  result_t skid_q, skid_d;
  logic    out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d = out_q;
    skid_d = skid_q;
    if (out_free) begin
      if (skid_valid_q) begin
        out_valid_d = 1'b1;
        out_d = skid_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = push_i;
        out_d = push_data_i;
      end
    end else if (push_i) begin
      skid_valid_d = 1'b1;
      skid_d = push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    skid_q <= skid_d;
  end

  assign full_o = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o = out_q;

endmodule
